FILE: src/mu8_pkg.sv
// Shared types and constants of the modified UTF-8 decoder.
package mu8_pkg;

   localparam int MAX_RES    = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic [1:0]  CONT_TAG       = 2'b10;
   localparam logic [2:0]  LEAD_TWO_TAG   = 3'b110;
   localparam logic [3:0]  LEAD_THREE_TAG = 4'b1110;
   localparam logic [7:0]  SURR_LEAD      = 8'hED;
   localparam logic [3:0]  SURR_LOW_NIB   = 4'hB;
   localparam logic [15:0] HIGH_FIRST     = 16'hD800;
   localparam logic [15:0] HIGH_LAST      = 16'hDBFF;
   localparam logic [20:0] SUPP_BASE      = 21'h10000;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;

   typedef enum logic [2:0] {
      POS_LEAD,
      POS_TWO_1,
      POS_THREE_1,
      POS_THREE_2,
      POS_HELD,
      POS_HELD_ED,
      POS_HELD_EDB
   } pos_type;

   typedef enum logic [1:0] {
      ST_CODE,
      ST_MALFORMED,
      ST_TRUNCATED,
      ST_END_ONLY
   } status_type;

   typedef struct packed {
      logic [20:0] code_point;
      status_type  status;
      logic        last;
   } res_type;

   // All results caused by one input byte
   typedef struct packed {
      logic [1:0]                count;
      res_type [MAX_RES-1:0]     res;
   } rec_type;

endpackage

FILE: src/mu8_if.sv
// Channel interfaces for the byte input and the result output.
interface mu8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_string;

   modport source  (output valid, byte_value, end_of_string, input ready);
   modport sink    (input valid, byte_value, end_of_string, output ready);
   modport monitor (input valid, ready, byte_value, end_of_string);
endinterface

interface mu8_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [1:0]  status;
   logic        last;

   modport source  (output valid, code_point, status, last, input ready);
   modport sink    (input valid, code_point, status, last, output ready);
   modport monitor (input valid, ready, code_point, status, last);
endinterface

FILE: src/mu8_front.sv
// Front end: takes one byte a beat, runs the sequence tracker, emits a result record.
module mu8_front (
   input  logic                clock,
   input  logic                reset,
   mu8_req_if.sink             req_chan,
   input  logic                q_full,
   output logic                q_push,
   output mu8_pkg::rec_type    q_rec
);

   mu8_pkg::pos_type pos_ff, pos_in;
   logic [15:0]      partial_ff, partial_in;
   logic [15:0]      unit_ff, unit_in;

   logic             fire;
   logic [7:0]       b;
   logic             cont;

   logic             lead_emit;
   logic [20:0]      lead_cp;
   mu8_pkg::status_type lead_st;
   mu8_pkg::pos_type lead_pos;
   logic [15:0]      lead_partial;

   logic             do_lead;
   logic [10:0]      v2;
   logic [15:0]      v3;
   mu8_pkg::rec_type rec;

   function automatic mu8_pkg::rec_type add(input mu8_pkg::rec_type r,
                                            input logic [20:0] cp,
                                            input mu8_pkg::status_type st);
      mu8_pkg::rec_type o;
      o = r;
      o.res[r.count] = '{code_point: cp, status: st, last: 1'b0};
      o.count = r.count + 2'd1;
      return o;
   endfunction

   assign req_chan.ready = !q_full;
   assign fire = req_chan.valid && req_chan.ready;
   assign b    = req_chan.byte_value;
   assign cont = (b[7:6] == mu8_pkg::CONT_TAG);
   assign v2   = {partial_ff[4:0], b[5:0]};
   assign v3   = {partial_ff[9:0], b[5:0]};

   // Decode of a byte taken as a lead
   always_comb begin
      lead_emit    = 1'b0;
      lead_cp      = '0;
      lead_st      = mu8_pkg::ST_CODE;
      lead_pos     = mu8_pkg::POS_LEAD;
      lead_partial = '0;
      if (!b[7]) begin
         lead_emit = 1'b1;
         lead_cp   = {13'd0, b};
      end else if (b[7:5] == mu8_pkg::LEAD_TWO_TAG) begin
         lead_pos     = mu8_pkg::POS_TWO_1;
         lead_partial = {11'd0, b[4:0]};
      end else if (b[7:4] == mu8_pkg::LEAD_THREE_TAG) begin
         lead_pos     = mu8_pkg::POS_THREE_1;
         lead_partial = {12'd0, b[3:0]};
      end else begin
         lead_emit = 1'b1;
         lead_st   = mu8_pkg::ST_MALFORMED;
      end
   end

   always_comb begin
      rec        = '0;
      pos_in     = pos_ff;
      partial_in = partial_ff;
      unit_in    = unit_ff;
      do_lead    = 1'b0;
      unique case (pos_ff)
         mu8_pkg::POS_TWO_1: begin
            if (cont) begin
               if (v2 != '0) rec = add(rec, {10'd0, v2}, mu8_pkg::ST_CODE);
               pos_in     = mu8_pkg::POS_LEAD;
               partial_in = '0;
            end else begin
               rec     = add(rec, '0, mu8_pkg::ST_MALFORMED);
               do_lead = 1'b1;
            end
         end
         mu8_pkg::POS_THREE_1: begin
            if (cont) begin
               partial_in = {6'd0, partial_ff[3:0], b[5:0]};
               pos_in     = mu8_pkg::POS_THREE_2;
            end else begin
               rec     = add(rec, '0, mu8_pkg::ST_MALFORMED);
               do_lead = 1'b1;
            end
         end
         mu8_pkg::POS_THREE_2: begin
            if (cont) begin
               partial_in = '0;
               if (v3 >= mu8_pkg::HIGH_FIRST && v3 <= mu8_pkg::HIGH_LAST) begin
                  unit_in = v3;
                  pos_in  = mu8_pkg::POS_HELD;
               end else begin
                  rec    = add(rec, {5'd0, v3}, mu8_pkg::ST_CODE);
                  pos_in = mu8_pkg::POS_LEAD;
               end
            end else begin
               rec     = add(rec, '0, mu8_pkg::ST_MALFORMED);
               do_lead = 1'b1;
            end
         end
         mu8_pkg::POS_HELD: begin
            if (b == mu8_pkg::SURR_LEAD) begin
               pos_in = mu8_pkg::POS_HELD_ED;
            end else begin
               rec     = add(rec, {5'd0, unit_ff}, mu8_pkg::ST_CODE);
               unit_in = '0;
               do_lead = 1'b1;
            end
         end
         mu8_pkg::POS_HELD_ED: begin
            if (b[7:4] == mu8_pkg::SURR_LOW_NIB) begin
               partial_in = {12'd0, b[3:0]};
               pos_in     = mu8_pkg::POS_HELD_EDB;
            end else if (cont) begin
               // broken pair: the ED starts an ordinary three-byte form
               rec        = add(rec, {5'd0, unit_ff}, mu8_pkg::ST_CODE);
               unit_in    = '0;
               partial_in = {6'd0, mu8_pkg::SURR_LEAD[3:0], b[5:0]};
               pos_in     = mu8_pkg::POS_THREE_2;
            end else begin
               rec     = add(rec, {5'd0, unit_ff}, mu8_pkg::ST_CODE);
               rec     = add(rec, '0, mu8_pkg::ST_MALFORMED);
               unit_in = '0;
               do_lead = 1'b1;
            end
         end
         mu8_pkg::POS_HELD_EDB: begin
            if (cont) begin
               rec = add(rec,
                         mu8_pkg::SUPP_BASE + {1'b0, unit_ff[9:0], partial_ff[3:0], b[5:0]},
                         mu8_pkg::ST_CODE);
               unit_in    = '0;
               partial_in = '0;
               pos_in     = mu8_pkg::POS_LEAD;
            end else begin
               rec     = add(rec, {5'd0, unit_ff}, mu8_pkg::ST_CODE);
               rec     = add(rec, '0, mu8_pkg::ST_MALFORMED);
               unit_in = '0;
               do_lead = 1'b1;
            end
         end
         default: begin
            do_lead = 1'b1;
         end
      endcase

      if (do_lead) begin
         if (lead_emit) rec = add(rec, lead_cp, lead_st);
         pos_in     = lead_pos;
         partial_in = lead_partial;
      end

      if (req_chan.end_of_string) begin
         // a held unit is still there only while waiting on its pair
         if (pos_in == mu8_pkg::POS_HELD || pos_in == mu8_pkg::POS_HELD_ED ||
             pos_in == mu8_pkg::POS_HELD_EDB)
            rec = add(rec, {5'd0, unit_in}, mu8_pkg::ST_CODE);
         if (pos_in != mu8_pkg::POS_LEAD && pos_in != mu8_pkg::POS_HELD)
            rec = add(rec, '0, mu8_pkg::ST_TRUNCATED);
         if (rec.count == 2'd0)
            rec = add(rec, '0, mu8_pkg::ST_END_ONLY);
         rec.res[rec.count - 2'd1].last = 1'b1;
         pos_in     = mu8_pkg::POS_LEAD;
         partial_in = '0;
         unit_in    = '0;
      end
   end

   assign q_push = fire && (rec.count != 2'd0);
   assign q_rec  = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= mu8_pkg::POS_LEAD;
         partial_ff <= '0;
         unit_ff    <= '0;
      end else if (fire) begin
         pos_ff     <= pos_in;
         partial_ff <= partial_in;
         unit_ff    <= unit_in;
      end
   end

endmodule

FILE: src/mu8_fifo.sv
// Short queue of result records between front and back.
module mu8_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mu8_pkg::rec_type    din,
   output logic                full,
   input  logic                pop,
   output mu8_pkg::rec_type    dout,
   output logic                empty
);

   mu8_pkg::rec_type             entries_ff [mu8_pkg::FIFO_DEPTH];
   logic [mu8_pkg::FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mu8_pkg::FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mu8_pkg::FIFO_AW:0]    fill_ff, fill_in;
   logic                         do_push, do_pop;

   assign full    = (fill_ff == (mu8_pkg::FIFO_AW+1)'(mu8_pkg::FIFO_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (mu8_pkg::FIFO_AW)'(do_push);
      rd_ptr_in = rd_ptr_ff + (mu8_pkg::FIFO_AW)'(do_pop);
      fill_in   = fill_ff + (mu8_pkg::FIFO_AW+1)'(do_push)
                          - (mu8_pkg::FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: src/mu8_back.sv
// Back end: unpacks result records into one result beat per cycle while rsp_chan is ready.
module mu8_back (
   input  logic                clock,
   input  logic                reset,
   input  mu8_pkg::rec_type    q_rec,
   input  logic                q_empty,
   output logic                q_pop,
   mu8_rsp_if.source           rsp_chan
);

   mu8_pkg::rec_type rec_ff, rec_in;
   logic             rec_valid_ff, rec_valid_in;
   logic [1:0]       idx_ff, idx_in;
   mu8_pkg::res_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             out_load, take, rec_done, rec_free;

   assign out_load = !out_valid_ff || rsp_chan.ready;
   assign take     = out_load && rec_valid_ff;
   assign rec_done = (idx_ff == rec_ff.count - 2'd1);
   assign rec_free = !rec_valid_ff || (take && rec_done);
   assign q_pop    = rec_free && !q_empty;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (take) begin
         out_in       = rec_ff.res[idx_ff];
         out_valid_in = 1'b1;
      end else if (out_load) begin
         out_valid_in = 1'b0;
      end

      rec_in       = rec_ff;
      rec_valid_in = rec_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         rec_in       = q_rec;
         rec_valid_in = 1'b1;
         idx_in       = '0;
      end else if (rec_free) begin
         rec_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_ff.code_point;
   assign rsp_chan.status     = out_ff.status;
   assign rsp_chan.last       = out_ff.last;

endmodule

FILE: src/modified_utf8_to_code_point.sv
// Top level of the modified UTF-8 to code point decoder.
//
// req_chan carries one byte of a class-file modified UTF-8 string per beat,
// with end_of_string on the final byte. rsp_chan carries decoded results:
// code_point with status 0, or a status beat for a malformed byte (1), a
// truncated form at string end (2) or an empty end step (3); last marks the
// final result of each string.
// A byte is taken every cycle while the four-entry record queue has room.
// Each byte gives zero to three results; the back end sends one result per
// cycle, so sustained input rate is one byte per cycle when bytes average
// at most one result, otherwise the result port (one beat a cycle) paces it.
// A byte's first result passes through the queue, record and output registers.
// A stalled receiver holds the output register; the queue then fills and
// req_chan.ready drops, with no beat lost.
// Reset clears the sequence tracker, the queue and the output register; no
// string is in progress afterwards.
module modified_utf8_to_code_point (
   input  logic       clock,
   input  logic       reset,
   mu8_req_if.sink    req_chan,
   mu8_rsp_if.source  rsp_chan
);

   logic             q_push, q_full, q_pop, q_empty;
   mu8_pkg::rec_type q_din, q_dout;

   mu8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_rec    (q_din)
   );

   mu8_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   mu8_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rec    (q_dout),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: src/mu8_checker.sv
// Port-level checks of the decoder, bound to the top level.
module mu8_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [20:0] rsp_code_point,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_code_point) &&
         $stable(rsp_status) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_status_zero_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mu8_pkg::ST_CODE |->
         rsp_code_point == '0)
      else $error("status beat carries a code point");

   a_end_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mu8_pkg::ST_END_ONLY ||
                    rsp_status == mu8_pkg::ST_TRUNCATED) |->
         rsp_last)
      else $error("end status without last");

   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_point <= mu8_pkg::CP_MAX)
      else $error("code point out of range");

endmodule

bind modified_utf8_to_code_point mu8_checker u_mu8_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_code_point (rsp_chan.code_point),
   .rsp_status     (rsp_chan.status),
   .rsp_last       (rsp_chan.last)
);

FILE: tb/modified_utf8_to_code_point_tb.sv
// Self-checking testbench for the modified UTF-8 to code point decoder.
`timescale 1ns / 100ps

module modified_utf8_to_code_point_tb;

   localparam int         RANDOM_BYTES = 430;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         HOLD_AFTER   = 150;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         RUN_LIMIT_NS = 200_000;
   localparam logic [3:0] HIGH_NIB     = 4'hA;   // ED Ax xx gives D800..DBFF

   // Decodes accepted bytes and holds the results still due from the block
   class code_point_scoreboard;
      mu8_pkg::pos_type pos;
      logic [15:0]      partial;
      logic [9:0]       held_hi;
      logic [15:0]      held_unit;
      logic             pending;
      mu8_pkg::res_type due_points[$];
      int               step_count;
      int               mismatches;
      int               points_checked;
      int               bytes_seen;
      int               strings_seen;
      int               status_count[4];

      function new();
         clear_state();
      endfunction

      function void clear_state();
         pos       = mu8_pkg::POS_LEAD;
         partial   = '0;
         held_hi   = '0;
         held_unit = '0;
         pending   = 1'b0;
      endfunction

      function void add_result(logic [20:0] cp, mu8_pkg::status_type st);
         mu8_pkg::res_type r;
         r.code_point = cp;
         r.status     = st;
         r.last       = 1'b0;
         due_points   = {due_points, r};
         status_count[int'(st)]++;
         step_count++;
      endfunction

      function void release_unit();
         add_result({5'd0, held_unit}, mu8_pkg::ST_CODE);
         pending   = 1'b0;
         held_unit = '0;
         held_hi   = '0;
      endfunction

      function void start_form(logic [7:0] b);
         partial = '0;
         if (b[7] == 1'b0) begin
            add_result({13'd0, b}, mu8_pkg::ST_CODE);
            pos = mu8_pkg::POS_LEAD;
         end else if (b[7:5] == mu8_pkg::LEAD_TWO_TAG) begin
            partial = {11'd0, b[4:0]};
            pos     = mu8_pkg::POS_TWO_1;
         end else if (b[7:4] == mu8_pkg::LEAD_THREE_TAG) begin
            partial = {12'd0, b[3:0]};
            pos     = mu8_pkg::POS_THREE_1;
         end else begin
            add_result('0, mu8_pkg::ST_MALFORMED);
            pos = mu8_pkg::POS_LEAD;
         end
      endfunction

      function void decode_byte(logic [7:0] b, logic eos);
         logic        cont;
         logic [10:0] two_val;
         logic [15:0] unit_val;
         logic [20:0] pair_val;
         cont       = (b[7:6] == mu8_pkg::CONT_TAG);
         step_count = 0;
         bytes_seen++;
         case (pos)
            mu8_pkg::POS_TWO_1: begin
               if (cont) begin
                  two_val = {partial[4:0], b[5:0]};
                  if (two_val != '0)
                     add_result({10'd0, two_val}, mu8_pkg::ST_CODE);
                  pos     = mu8_pkg::POS_LEAD;
                  partial = '0;
               end else begin
                  add_result('0, mu8_pkg::ST_MALFORMED);
                  start_form(b);
               end
            end
            mu8_pkg::POS_THREE_1: begin
               if (cont) begin
                  partial = {6'd0, partial[3:0], b[5:0]};
                  pos     = mu8_pkg::POS_THREE_2;
               end else begin
                  add_result('0, mu8_pkg::ST_MALFORMED);
                  start_form(b);
               end
            end
            mu8_pkg::POS_THREE_2: begin
               if (cont) begin
                  unit_val = {partial[9:0], b[5:0]};
                  partial  = '0;
                  if (unit_val >= mu8_pkg::HIGH_FIRST && unit_val <= mu8_pkg::HIGH_LAST) begin
                     held_unit = unit_val;
                     held_hi   = unit_val[9:0];
                     pending   = 1'b1;
                     pos       = mu8_pkg::POS_HELD;
                  end else begin
                     add_result({5'd0, unit_val}, mu8_pkg::ST_CODE);
                     pos = mu8_pkg::POS_LEAD;
                  end
               end else begin
                  add_result('0, mu8_pkg::ST_MALFORMED);
                  start_form(b);
               end
            end
            mu8_pkg::POS_HELD: begin
               if (b == mu8_pkg::SURR_LEAD) begin
                  pos = mu8_pkg::POS_HELD_ED;
               end else begin
                  release_unit();
                  start_form(b);
               end
            end
            mu8_pkg::POS_HELD_ED: begin
               if (b[7:4] == mu8_pkg::SURR_LOW_NIB) begin
                  partial = {12'd0, b[3:0]};
                  pos     = mu8_pkg::POS_HELD_EDB;
               end else if (cont) begin
                  // not a low unit: the ED starts an ordinary three-byte form
                  release_unit();
                  partial = {6'd0, mu8_pkg::SURR_LEAD[3:0], b[5:0]};
                  pos     = mu8_pkg::POS_THREE_2;
               end else begin
                  release_unit();
                  add_result('0, mu8_pkg::ST_MALFORMED);
                  start_form(b);
               end
            end
            mu8_pkg::POS_HELD_EDB: begin
               if (cont) begin
                  pair_val = mu8_pkg::SUPP_BASE + {held_hi, 10'd0} + {partial[3:0], 6'd0}
                             + b[5:0];
                  add_result(pair_val, mu8_pkg::ST_CODE);
                  clear_state();
               end else begin
                  release_unit();
                  add_result('0, mu8_pkg::ST_MALFORMED);
                  start_form(b);
               end
            end
            default: start_form(b);
         endcase

         if (eos) begin
            strings_seen++;
            if (pending)
               release_unit();
            if (pos != mu8_pkg::POS_LEAD && pos != mu8_pkg::POS_HELD)
               add_result('0, mu8_pkg::ST_TRUNCATED);
            if (step_count == 0)
               add_result('0, mu8_pkg::ST_END_ONLY);
            due_points[due_points.size() - 1].last = 1'b1;
            clear_state();
         end
      endfunction

      function void check_point(logic [20:0] cp, logic [1:0] st, logic lst);
         mu8_pkg::res_type want;
         points_checked++;
         if (due_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %0d: cp=%h status=%0d last=%b",
                        points_checked, cp, st, lst);
         end else begin
            want = due_points.pop_front();
            if (cp !== want.code_point || st !== want.status || lst !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected cp=%h status=%0d last=%b, got cp=%h status=%0d last=%b",
                           points_checked, want.code_point, want.status, want.last,
                           cp, st, lst);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mu8_req_if req_chan ();
   mu8_rsp_if rsp_chan ();

   modified_utf8_to_code_point u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   code_point_scoreboard sb;
   logic [7:0]           plan_bytes[$];
   logic                 plan_ends[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_point(rsp_chan.code_point, rsp_chan.status, rsp_chan.last);
         if (req_chan.valid && req_chan.ready)
            sb.decode_byte(req_chan.byte_value, req_chan.end_of_string);
      end
   end

   function automatic logic [7:0] rand_cont();
      logic [5:0] r6;
      r6 = 6'($urandom_range(0, 63));
      return {mu8_pkg::CONT_TAG, r6};
   endfunction

   // anything but a continuation byte
   function automatic logic [7:0] non_cont();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == mu8_pkg::CONT_TAG)
         b[6] = 1'b1;
      return b;
   endfunction

   task automatic plan(input logic [7:0] b);
      plan_bytes = {plan_bytes, b};
      plan_ends  = {plan_ends, 1'b0};
   endtask

   task automatic end_string();
      plan_ends[plan_ends.size() - 1] = 1'b1;
   endtask

   task automatic plan_high_unit();
      logic [3:0] nib;
      nib = 4'($urandom_range(0, 15));
      plan(mu8_pkg::SURR_LEAD);
      plan({HIGH_NIB, nib});
      plan(rand_cont());
   endtask

   task automatic plan_unit();
      logic [3:0] nib;
      logic [4:0] top5;
      int         kind;
      kind = $urandom_range(0, 11);
      nib  = 4'($urandom_range(0, 15));
      top5 = 5'($urandom_range(0, 31));
      case (kind)
         0, 1: plan(8'($urandom_range(0, 127)));
         2: begin
            if ($urandom_range(0, 3) == 0) begin
               plan({mu8_pkg::LEAD_TWO_TAG, 5'd0});
               plan({mu8_pkg::CONT_TAG, 6'd0});
            end else begin
               plan({mu8_pkg::LEAD_TWO_TAG, top5});
               plan(rand_cont());
            end
         end
         3: begin
            plan({mu8_pkg::LEAD_THREE_TAG, nib});
            plan(rand_cont());
            plan(rand_cont());
         end
         4: plan_high_unit();
         5, 6: begin
            plan_high_unit();
            plan(mu8_pkg::SURR_LEAD);
            plan({mu8_pkg::SURR_LOW_NIB, nib});
            plan(rand_cont());
         end
         7: begin
            // pair that breaks after its second lead
            plan_high_unit();
            plan(mu8_pkg::SURR_LEAD);
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  plan(8'($urandom_range(8'h80, 8'hAF)));
                  plan(rand_cont());
               end
               2: plan(non_cont());
               default: plan({mu8_pkg::SURR_LOW_NIB, nib});
            endcase
         end
         8: begin
            plan_high_unit();
            plan(mu8_pkg::SURR_LEAD);
            plan({mu8_pkg::SURR_LOW_NIB, nib});
            plan(non_cont());
         end
         9: plan(8'($urandom_range(0, 255)));
         10: begin
            // unfinished form, broken by whatever follows
            if ($urandom_range(0, 1) == 0) begin
               plan({mu8_pkg::LEAD_TWO_TAG, top5});
            end else begin
               plan({mu8_pkg::LEAD_THREE_TAG, nib});
               if ($urandom_range(0, 1) == 0)
                  plan(rand_cont());
            end
         end
         default: begin
            plan(mu8_pkg::SURR_LEAD);
            plan(8'($urandom_range(8'h80, 8'hBF)));
            plan(rand_cont());
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.byte_value    <= b;
      req_chan.end_of_string <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // result side: random stalls, bursts with none, and one long hold-off
   initial begin : result_sink
      int taken;
      int gap;
      taken = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = (((taken / 40) % 3) == 1) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : byte_source
      int directed_count;
      int gap;
      sb = new();
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.byte_value    <= 8'h00;
      req_chan.end_of_string <= 1'b0;

      // extremes, zero from two bytes, max pair, bad leads, broken and unfinished forms
      plan(8'h00); plan(8'h7F);
      plan(8'hC0); plan(8'h80);
      plan(8'hDF); plan(8'hBF);
      plan(8'hEF); plan(8'hBF); plan(8'hBF);
      plan(8'hED); plan(8'hAF); plan(8'hBF); plan(8'hED); plan(8'hBF); plan(8'hBF);
      plan(8'h80); plan(8'hFF);
      plan(8'hC2); plan(8'h41);
      plan(8'hE2); plan(8'h82); end_string();
      plan(8'hC0); plan(8'h80); end_string();
      plan(8'hED); plan(8'hA0); plan(8'h80); end_string();
      directed_count = plan_bytes.size();

      while (plan_bytes.size() < directed_count + RANDOM_BYTES) begin
         repeat ($urandom_range(1, 5)) plan_unit();
         end_string();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < plan_bytes.size(); i++) begin
         gap = (((i / 40) % 3) == 2) ? 0 : $urandom_range(0, 6);
         send_byte(plan_bytes[i], plan_ends[i], gap);
      end
      req_chan.valid <= 1'b0;
      // let the final beat reach the scoreboard before looking at what is due
      @(posedge clock);

      while (sb.due_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("decoded %0d bytes in %0d strings, %0d results checked",
               sb.bytes_seen, sb.strings_seen, sb.points_checked);
      $display("code points %0d, malformed %0d, truncated %0d, end only %0d; mismatches %0d",
               sb.status_count[0], sb.status_count[1], sb.status_count[2],
               sb.status_count[3], sb.mismatches);
      if (sb.due_points.size() != 0)
         $display("%0d expected results never arrived", sb.due_points.size());
      if (sb.mismatches == 0 && sb.due_points.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
